@@ hw/rtl/sha256_pkg.sv @@
package sha256_pkg;

  localparam int unsigned ROUNDS = 64;
  localparam int unsigned WIN_DEPTH = 16;
  localparam int unsigned BLOCK_BITS = 512;
  localparam int unsigned CHAIN_BITS = 256;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] FILL_LEN = 6'd56;

  localparam logic [CHAIN_BITS-1:0] IV_FLAT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_EMIT
  } hash_state_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ROUND,
    CS_FOLD
  } core_state_t;

  typedef struct packed {
    logic start;
    logic init;
  } core_ctl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

@@ hw/rtl/sha256_core.sv @@
module sha256_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sha256_pkg::core_ctl_t               ctl,
  input  logic [sha256_pkg::BLOCK_BITS-1:0]   block,
  output logic                                done,
  output logic [sha256_pkg::CHAIN_BITS-1:0]   chain_flat
);
  import sha256_pkg::*;

  core_state_t state_r, state_nxt;
  logic [5:0]  cnt_r;
  logic        done_r;
  logic [31:0] win_r   [WIN_DEPTH];
  logic [31:0] var_r   [8];
  logic [31:0] chain_r [8];

  logic [31:0] w_new, t1, t2, ch, maj;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE:  if (ctl.start) state_nxt = CS_ROUND;
      CS_ROUND: if (cnt_r == 6'(ROUNDS - 1)) state_nxt = CS_FOLD;
      CS_FOLD:  state_nxt = CS_IDLE;
      default:  state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    w_new = ssig1(win_r[14]) + win_r[9] + ssig0(win_r[1]) + win_r[0];
    ch    = (var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]);
    maj   = (var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]);
    t1    = var_r[7] + bsig1(var_r[4]) + ch + ROUND_K[cnt_r] + win_r[0];
    t2    = bsig0(var_r[0]) + maj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == CS_FOLD);
      if (state_r == CS_ROUND) cnt_r <= cnt_r + 6'd1;
      else cnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= IV_FLAT[CHAIN_BITS-1-32*i -: 32];
    end else if (state_r == CS_FOLD) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + var_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == CS_IDLE && ctl.start) begin
      for (int i = 0; i < WIN_DEPTH; i++) win_r[i] <= block[BLOCK_BITS-1-32*i -: 32];
      for (int i = 0; i < 8; i++) var_r[i] <= chain_r[i];
    end else if (state_r == CS_ROUND) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) win_r[i] <= win_r[i+1];
      win_r[WIN_DEPTH-1] <= w_new;
      var_r[7] <= var_r[6];
      var_r[6] <= var_r[5];
      var_r[5] <= var_r[4];
      var_r[4] <= var_r[3] + t1;
      var_r[3] <= var_r[2];
      var_r[2] <= var_r[1];
      var_r[1] <= var_r[0];
      var_r[0] <= t1 + t2;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) chain_flat[CHAIN_BITS-1-32*i -: 32] = chain_r[i];
  end

  assign done = done_r;

endmodule

@@ hw/rtl/sha256_stream_hasher_unit.sv @@
// SHA-256 over a byte stream. Each input item may carry one message byte
// (in_byte_valid) and may close the message (in_end_of_message); a closing item
// yields four 64-bit digest words, most significant first, with out_last_word
// on the fourth, and the hasher then restarts with the initial hash values.
// A byte that does not complete a 64-byte block is taken without stalling the
// input. A byte that completes a block holds the input off while the single
// round unit loads the block, runs 64 rounds, one per clock, updates the chain
// and raises done. Closing a message shifts the padding and length in at one
// byte per cycle, except while a compression holds it off, runs one or two
// more compressions, then presents the four digest words; no input is taken
// until the last word is accepted.
module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word,
  output logic        out_last_word
);
  import sha256_pkg::*;

  hash_state_t state_r, state_nxt;

  logic [BLOCK_BITS-1:0] msg_r, msg_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic        pad_r, pad_nxt;
  logic        mark_r, mark_nxt;
  logic        mark_hi_r, mark_hi_nxt;
  logic        last_blk_r, last_blk_nxt;
  logic        start_r, start_nxt;
  logic [1:0]  widx_r, widx_nxt;

  logic        push;
  logic [7:0]  push_byte;
  logic [7:0]  len_byte;
  logic        init;
  logic        core_done;
  logic [CHAIN_BITS-1:0] chain_flat;
  core_ctl_t   ctl;

  assign len_byte = 8'(bits_r >> {3'd7 - fill_r[2:0], 3'b000});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_byte_valid && fill_r == FILL_LAST) state_nxt = ST_COMP;
          else if (in_end_of_message) state_nxt = ST_PAD;
        end
      end
      ST_PAD:  if (fill_r == FILL_LAST) state_nxt = ST_COMP;
      ST_COMP: begin
        if (core_done) begin
          if (last_blk_r) state_nxt = ST_EMIT;
          else if (pad_r) state_nxt = ST_PAD;
          else state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: if (!out_stall && widx_r == 2'd3) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    msg_nxt      = msg_r;
    fill_nxt     = fill_r;
    bits_nxt     = bits_r;
    pad_nxt      = pad_r;
    mark_nxt     = mark_r;
    mark_hi_nxt  = mark_hi_r;
    last_blk_nxt = last_blk_r;
    start_nxt    = 1'b0;
    widx_nxt     = widx_r;
    push         = 1'b0;
    push_byte    = in_data_byte;
    init         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_byte_valid) begin
            push     = 1'b1;
            bits_nxt = bits_r + 64'd8;
          end
          if (in_end_of_message) pad_nxt = 1'b1;
        end
      end
      ST_PAD: begin
        push = 1'b1;
        if (!mark_r) begin
          push_byte   = PAD_MARK;
          mark_nxt    = 1'b1;
          mark_hi_nxt = (fill_r >= FILL_LEN);
        end else if (fill_r >= FILL_LEN && !mark_hi_r) begin
          push_byte = len_byte;
        end else begin
          push_byte = '0;
        end
      end
      ST_COMP: begin
      end
      ST_EMIT: begin
        if (!out_stall) begin
          widx_nxt = widx_r + 2'd1;
          if (widx_r == 2'd3) begin
            init         = 1'b1;
            fill_nxt     = '0;
            bits_nxt     = '0;
            pad_nxt      = 1'b0;
            mark_nxt     = 1'b0;
            mark_hi_nxt  = 1'b0;
            last_blk_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    if (push) begin
      msg_nxt = {msg_r[BLOCK_BITS-9:0], push_byte};
      if (fill_r == FILL_LAST) begin
        fill_nxt     = '0;
        start_nxt    = 1'b1;
        last_blk_nxt = (state_r == ST_PAD) && !mark_hi_nxt;
        mark_hi_nxt  = 1'b0;
      end else begin
        fill_nxt = fill_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= '0;
      bits_r     <= '0;
      pad_r      <= 1'b0;
      mark_r     <= 1'b0;
      mark_hi_r  <= 1'b0;
      last_blk_r <= 1'b0;
      start_r    <= 1'b0;
      widx_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      bits_r     <= bits_nxt;
      pad_r      <= pad_nxt;
      mark_r     <= mark_nxt;
      mark_hi_r  <= mark_hi_nxt;
      last_blk_r <= last_blk_nxt;
      start_r    <= start_nxt;
      widx_r     <= widx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    msg_r <= msg_nxt;
  end

  assign ctl.start = start_r;
  assign ctl.init  = init;

  sha256_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .block      (msg_r),
    .done       (core_done),
    .chain_flat (chain_flat)
  );

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_EMIT);
  assign out_digest_word = chain_flat[{~widx_r, 6'd0} +: 64];
  assign out_last_word   = (widx_r == 2'd3);

endmodule
